FILE: hdl/spsi_pkg.sv
// ----------------------------------------------------------------------------
// spsi_pkg
// types, codes and sizes shared by the sorted participant set blocks
// ----------------------------------------------------------------------------
package spsi_pkg;

   localparam int MAX_PARTICIPANTS = 16;
   localparam int POS_W            = $clog2(MAX_PARTICIPANTS);
   localparam int FILL_W           = $clog2(MAX_PARTICIPANTS + 1);
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // outcome codes
   localparam logic [2:0] OUT_INSERTED = 3'd0;
   localparam logic [2:0] OUT_MERGED   = 3'd1;
   localparam logic [2:0] OUT_RANGE    = 3'd2;
   localparam logic [2:0] OUT_MISMATCH = 3'd3;
   localparam logic [2:0] OUT_FULL     = 3'd4;
   localparam logic [2:0] OUT_FOUND    = 3'd5;
   localparam logic [2:0] OUT_MISSING  = 3'd6;

   // register index
   localparam logic REG_SLOT_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] edge_index;
      logic        local_flag;
      logic        gate_flag;
      logic [2:0]  expected_status;
   } req_type;

   typedef struct packed {
      logic [2:0]        outcome;
      logic              entry_local;
      logic              entry_gate;
      logic [2:0]        entry_status;
      logic [POS_W-1:0]  entry_position;
      logic [FILL_W-1:0] table_fill;
   } rsp_type;

   typedef struct packed {
      logic [31:0] idx;
      logic        local_flag;
      logic        gate_flag;
      logic [2:0]  status;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      entry_type        fresh;
      logic [POS_W-1:0] at_pos;
      logic             do_insert;
      logic             do_merge;
   } bcast_type;

endpackage

FILE: hdl/sorted_participant_set_insert.sv
// ----------------------------------------------------------------------------
// sorted_participant_set_insert
// sorted, duplicate-free table of participant entries with insert and lookup
// ----------------------------------------------------------------------------
// For each command the beat is latched when start is high and busy low, then
// busy stays high during the evaluate cycle in which every cell of
// the 16-slot chain compares its index with the key at once and the table is
// updated (shift up, merge or nothing). The result beat appears on rsp_data
// with rsp_valid for exactly the cycle after that, and the receiver cannot
// stall it; a new command may be started in that same cycle. A clear (and
// the unused command code) produces no result beat. Reset empties the table
// and sets slot_count to 0, so every insert is out of range until written.
module sorted_participant_set_insert (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  spsi_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   output spsi_pkg::rsp_type               rsp_data,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [spsi_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spsi_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spsi_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import spsi_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic                state_ff, state_in;
   req_type             req_ff;
   logic [FILL_W-1:0]   count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [31:0]         slot_count;

   bcast_type           bcast;
   entry_type           cell_entry   [MAX_PARTICIPANTS];
   logic                cell_match   [MAX_PARTICIPANTS];
   logic                cell_greater [MAX_PARTICIPANTS];
   logic                cell_valid   [MAX_PARTICIPANTS];

   logic                any_match, any_greater;
   logic [POS_W-1:0]    match_pos, greater_pos, at_pos;
   entry_type           hit;
   logic                accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_EVAL);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register port
   spsi_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .slot_count (slot_count)
   );

   // chain of cells, cell 0 holds the smallest index
   for (genvar i = 0; i < MAX_PARTICIPANTS; i++) begin : g_cell
      assign cell_valid[i] = (FILL_W'(i) < count_ff);
      if (i == 0) begin : g_head
         spsi_cell u_cell (
            .clock        (clock),
            .bcast        (bcast),
            .cell_pos     (POS_W'(i)),
            .cell_valid   (cell_valid[i]),
            .left_entry   ('0),
            .left_greater (1'b0),
            .entry        (cell_entry[i]),
            .match        (cell_match[i]),
            .greater      (cell_greater[i])
         );
      end else begin : g_body
         spsi_cell u_cell (
            .clock        (clock),
            .bcast        (bcast),
            .cell_pos     (POS_W'(i)),
            .cell_valid   (cell_valid[i]),
            .left_entry   (cell_entry[i-1]),
            .left_greater (cell_greater[i-1]),
            .entry        (cell_entry[i]),
            .match        (cell_match[i]),
            .greater      (cell_greater[i])
         );
      end
   end

   // lowest matching cell and lowest greater cell (the insertion point)
   always_comb begin
      any_match   = 1'b0;
      any_greater = 1'b0;
      match_pos   = '0;
      greater_pos = '0;
      for (int i = MAX_PARTICIPANTS - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            any_match = 1'b1;
            match_pos = POS_W'(i);
         end
         if (cell_greater[i]) begin
            any_greater = 1'b1;
            greater_pos = POS_W'(i);
         end
      end
   end

   assign at_pos = any_greater ? greater_pos : count_ff[POS_W-1:0];
   assign hit    = cell_entry[match_pos];

   // command decode in the evaluate cycle
   always_comb begin
      bcast.fresh.idx        = req_ff.edge_index;
      bcast.fresh.local_flag = req_ff.local_flag;
      bcast.fresh.gate_flag  = req_ff.gate_flag;
      bcast.fresh.status     = req_ff.expected_status;
      bcast.at_pos           = at_pos;
      bcast.do_insert        = 1'b0;
      bcast.do_merge         = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            case (req_ff.cmd)
               CMD_INSERT: begin
                  rsp_valid_in = 1'b1;
                  if (req_ff.edge_index >= slot_count) begin
                     rsp_data_in.outcome = OUT_RANGE;
                  end else if (any_match) begin
                     rsp_data_in.entry_status   = hit.status;
                     rsp_data_in.entry_position = match_pos;
                     if (hit.status != req_ff.expected_status) begin
                        rsp_data_in.outcome     = OUT_MISMATCH;
                        rsp_data_in.entry_local = hit.local_flag;
                        rsp_data_in.entry_gate  = hit.gate_flag;
                     end else begin
                        bcast.do_merge          = 1'b1;
                        rsp_data_in.outcome     = OUT_MERGED;
                        rsp_data_in.entry_local = hit.local_flag | req_ff.local_flag;
                        rsp_data_in.entry_gate  = hit.gate_flag | req_ff.gate_flag;
                     end
                  end else if (count_ff >= FILL_W'(MAX_PARTICIPANTS)) begin
                     rsp_data_in.outcome = OUT_FULL;
                  end else begin
                     bcast.do_insert            = 1'b1;
                     count_in                   = count_ff + FILL_W'(1);
                     rsp_data_in.outcome        = OUT_INSERTED;
                     rsp_data_in.entry_local    = req_ff.local_flag;
                     rsp_data_in.entry_gate     = req_ff.gate_flag;
                     rsp_data_in.entry_status   = req_ff.expected_status;
                     rsp_data_in.entry_position = at_pos;
                  end
               end
               CMD_LOOKUP: begin
                  rsp_valid_in = 1'b1;
                  if (any_match) begin
                     rsp_data_in.outcome        = OUT_FOUND;
                     rsp_data_in.entry_local    = hit.local_flag;
                     rsp_data_in.entry_gate     = hit.gate_flag;
                     rsp_data_in.entry_status   = hit.status;
                     rsp_data_in.entry_position = match_pos;
                  end else begin
                     rsp_data_in.outcome = OUT_MISSING;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  // unused code, no effect and no beat
               end
            endcase
            rsp_data_in.table_fill = count_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // a result beat only follows an evaluate cycle
   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EVAL))
      else $error("result beat without evaluate cycle");

   // the fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FILL_W'(MAX_PARTICIPANTS))
      else $error("entry count beyond table depth");

   // an accepted command holds the block busy for the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   // the reported fill matches the live entry count
   a_fill_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.table_fill == count_ff))
      else $error("reported fill differs from entry count");

endmodule

FILE: hdl/spsi_cell.sv
// ----------------------------------------------------------------------------
// spsi_cell
// one table slot: compares against the key and shifts or merges on update
// ----------------------------------------------------------------------------
module spsi_cell (
   input  logic                      clock,
   input  spsi_pkg::bcast_type       bcast,
   input  logic [spsi_pkg::POS_W-1:0] cell_pos,
   input  logic                      cell_valid,
   input  spsi_pkg::entry_type       left_entry,
   input  logic                      left_greater,
   output spsi_pkg::entry_type       entry,
   output logic                      match,
   output logic                      greater
);
   import spsi_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign entry   = entry_ff;
   assign match   = cell_valid && (entry_ff.idx == bcast.fresh.idx);
   assign greater = cell_valid && (bcast.fresh.idx < entry_ff.idx);

   always_comb begin
      entry_in = entry_ff;
      if (bcast.do_insert && (cell_pos == bcast.at_pos)) begin
         entry_in = bcast.fresh;
      end else if (bcast.do_insert && left_greater) begin
         // later entries move up one slot
         entry_in = left_entry;
      end else if (bcast.do_merge && match) begin
         entry_in.local_flag = entry_ff.local_flag | bcast.fresh.local_flag;
         entry_in.gate_flag  = entry_ff.gate_flag | bcast.fresh.gate_flag;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hdl/spsi_csr.sv
// ----------------------------------------------------------------------------
// spsi_csr
// register port holding the slot count
// ----------------------------------------------------------------------------
module spsi_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [spsi_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spsi_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spsi_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic [31:0]                     slot_count
);
   import spsi_pkg::*;

   logic [31:0] slot_count_ff;
   logic [31:0] slot_count_in;
   logic        reg_index;

   assign reg_index = paddr[CSR_ADDR_W-1];
   assign pready    = 1'b1;
   assign slot_count = slot_count_ff;

   always_comb begin
      slot_count_in = slot_count_ff;
      if (psel && penable && pwrite && (reg_index == REG_SLOT_COUNT)) begin
         slot_count_in = pwdata;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_SLOT_COUNT) begin
         prdata = slot_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
      end else begin
         slot_count_ff <= slot_count_in;
      end
   end

endmodule
